// File: rtl/vstl_pkg.sv
// ----------------------------------------------------------------------------
// vstl_pkg
// Types, widths, codes and constant tables shared by the throttle limiter.
// ----------------------------------------------------------------------------
package vstl_pkg;

   localparam int unsigned VOLT_W      = 16;
   localparam int unsigned PULSE_W     = 12;
   localparam int unsigned CMD_SUM_W   = 14;
   localparam int unsigned LIMIT_W     = 14;
   localparam int unsigned PCT_W       = 9;
   localparam int unsigned STEP_W      = 7;
   localparam int unsigned TIME_W      = 32;
   localparam int unsigned RAMP_STEP_W = 10;
   localparam int unsigned FLOOR_W     = 12;
   localparam int unsigned TEST_STEP_W = 16;
   localparam int unsigned CSR_IDX_W   = 2;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam int unsigned MODE_W      = 2;
   localparam int unsigned EVENT_W     = 2;

   localparam int unsigned PULSE_MIN_VAL = 995;
   localparam int unsigned PULSE_MAX_VAL = 1989;
   localparam int unsigned PULSE_SPAN    = PULSE_MAX_VAL - PULSE_MIN_VAL;
   localparam int unsigned PCT_SCALE     = 100;
   localparam int unsigned SWEEP_STEPS   = 101;

   localparam logic [PULSE_W-1:0] PULSE_MIN    = PULSE_W'(PULSE_MIN_VAL);
   localparam logic [PULSE_W-1:0] PULSE_MAX    = PULSE_W'(PULSE_MAX_VAL);
   localparam logic [PULSE_W-1:0] SWITCH_LEVEL = 12'd1600;
   localparam logic [STEP_W-1:0]  SWEEP_END    = 7'd100;
   localparam logic [PCT_W-1:0]   PERCENT_SAT  = 9'd311;

   // percent = (x - min) * 100 / 994 = n * 50 / 497, done as n * 50 * ceil(2^32 / 497) >> 32
   localparam int unsigned PCT_SHIFT     = 32;
   localparam int unsigned PCT_HALF_SPAN = PULSE_SPAN / 2;
   localparam int unsigned PCT_DIFF_W    = 13;
   localparam int unsigned PCT_MULT_W    = 29;
   localparam int unsigned PCT_PROD_W    = PCT_DIFF_W + PCT_MULT_W;
   localparam int unsigned PCT_Q_W       = PCT_PROD_W - PCT_SHIFT;
   localparam logic [PCT_MULT_W-1:0] PCT_MULT = PCT_MULT_W'((PCT_SCALE / 2) *
      (((64'd1 << PCT_SHIFT) + PCT_HALF_SPAN - 1) / PCT_HALF_SPAN));

   localparam logic [VOLT_W-1:0]      RST_VOLTAGE_LIMIT = 16'd12000;
   localparam logic [RAMP_STEP_W-1:0] RST_RAMP_STEP     = 10'd20;
   localparam logic [FLOOR_W-1:0]     RST_RAMP_FLOOR    = 12'd0;
   localparam logic [TEST_STEP_W-1:0] RST_TEST_STEP     = 16'd1000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VOLTAGE_LIMIT = 2'd0,
      CSR_RAMP_STEP     = 2'd1,
      CSR_RAMP_FLOOR    = 2'd2,
      CSR_TEST_STEP     = 2'd3
   } csr_index_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_MANUAL = 2'd0,
      MODE_AUTO   = 2'd1,
      MODE_TEST   = 2'd2
   } drive_mode_type;

   typedef enum logic [EVENT_W-1:0] {
      EVENT_NONE  = 2'd0,
      EVENT_START = 2'd1,
      EVENT_STEP  = 2'd2,
      EVENT_END   = 2'd3
   } serial_event_type;

   typedef struct packed {
      logic [VOLT_W-1:0]  voltage_mv;
      logic [PULSE_W-1:0] pulse_a;
      logic [PULSE_W-1:0] pulse_b;
      logic [PULSE_W-1:0] pulse_c;
      logic [PULSE_W-1:0] pulse_d;
      logic [PULSE_W-1:0] switch_pulse_a;
      logic [PULSE_W-1:0] switch_pulse_b;
      logic               test_toggle;
      logic [TIME_W-1:0]  now_ms;
   } req_item_type;

   typedef struct packed {
      logic [PULSE_W-1:0] esc_pulse_us;
      drive_mode_type     drive_mode;
      logic [PCT_W-1:0]   ramp_percent;
      logic [PCT_W-1:0]   command_percent;
      logic [VOLT_W-1:0]  mean_voltage_mv;
      serial_event_type   serial_event;
      logic [STEP_W-1:0]  serial_step;
   } rsp_item_type;

   typedef logic [SWEEP_STEPS-1:0][PULSE_W-1:0] test_pulse_table_type;

   function automatic test_pulse_table_type build_test_pulse_table();
      test_pulse_table_type t;
      for (int i = 0; i < SWEEP_STEPS; i++) begin
         t[i] = PULSE_W'(PULSE_MIN_VAL + (i * PULSE_SPAN) / PCT_SCALE);
      end
      return t;
   endfunction

   localparam test_pulse_table_type TEST_PULSE_TABLE = build_test_pulse_table();

   function automatic logic [PCT_W-1:0] pulse_to_percent(input logic signed [LIMIT_W-1:0] x);
      logic signed [LIMIT_W-1:0] diff;
      logic [PCT_PROD_W-1:0]     prod;
      logic [PCT_Q_W-1:0]        q;
      diff = x - $signed({2'b00, PULSE_MIN});
      prod = PCT_PROD_W'(diff[PCT_DIFF_W-1:0]) * PCT_PROD_W'(PCT_MULT);
      q    = prod[PCT_PROD_W-1:PCT_SHIFT];
      if (x <= $signed({2'b00, PULSE_MIN})) begin
         return '0;
      end
      if (q > PCT_Q_W'(PERCENT_SAT)) begin
         return PERCENT_SAT;
      end
      return q[PCT_W-1:0];
   endfunction

endpackage

// File: rtl/vstl_if.sv
// ----------------------------------------------------------------------------
// vstl_req_if / vstl_rsp_if
// Valid/ready channels for sensor items in and throttle result items out.
// ----------------------------------------------------------------------------
interface vstl_req_if;
   import vstl_pkg::*;

   logic               valid;
   logic               ready;
   logic [VOLT_W-1:0]  voltage_mv;
   logic [PULSE_W-1:0] pulse_a;
   logic [PULSE_W-1:0] pulse_b;
   logic [PULSE_W-1:0] pulse_c;
   logic [PULSE_W-1:0] pulse_d;
   logic [PULSE_W-1:0] switch_pulse_a;
   logic [PULSE_W-1:0] switch_pulse_b;
   logic               test_toggle;
   logic [TIME_W-1:0]  now_ms;

   modport source (
      output valid, voltage_mv, pulse_a, pulse_b, pulse_c, pulse_d,
             switch_pulse_a, switch_pulse_b, test_toggle, now_ms,
      input  ready
   );
   modport sink (
      input  valid, voltage_mv, pulse_a, pulse_b, pulse_c, pulse_d,
             switch_pulse_a, switch_pulse_b, test_toggle, now_ms,
      output ready
   );
endinterface

interface vstl_rsp_if;
   import vstl_pkg::*;

   logic               valid;
   logic               ready;
   logic [PULSE_W-1:0] esc_pulse_us;
   logic [MODE_W-1:0]  drive_mode;
   logic [PCT_W-1:0]   ramp_percent;
   logic [PCT_W-1:0]   command_percent;
   logic [VOLT_W-1:0]  mean_voltage_mv;
   logic [EVENT_W-1:0] serial_event;
   logic [STEP_W-1:0]  serial_step;

   modport source (
      output valid, esc_pulse_us, drive_mode, ramp_percent, command_percent,
             mean_voltage_mv, serial_event, serial_step,
      input  ready
   );
   modport sink (
      input  valid, esc_pulse_us, drive_mode, ramp_percent, command_percent,
             mean_voltage_mv, serial_event, serial_step,
      output ready
   );
endinterface

// File: rtl/vstl_mean.sv
// ----------------------------------------------------------------------------
// vstl_mean
// Running mean of the last AVG_DEPTH voltages, kept as a ring and a total.
// ----------------------------------------------------------------------------
module vstl_mean #(
   parameter int unsigned AVG_DEPTH = 5
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        enable,
   input  logic [vstl_pkg::VOLT_W-1:0] voltage,
   output logic [vstl_pkg::VOLT_W-1:0] mean
);
   import vstl_pkg::*;

   localparam int unsigned DEPTH_LOG = $clog2(AVG_DEPTH);
   localparam int unsigned SLOT_W    = (AVG_DEPTH > 1) ? DEPTH_LOG : 1;
   localparam int unsigned SUM_W     = VOLT_W + DEPTH_LOG;
   localparam int unsigned SHIFT     = SUM_W + DEPTH_LOG;
   localparam int unsigned RECIP_W   = SHIFT + 1;
   localparam int unsigned PROD_W    = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << SHIFT) + AVG_DEPTH - 1) / AVG_DEPTH);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(AVG_DEPTH - 1);

   logic [VOLT_W-1:0] hist_ff [AVG_DEPTH];
   logic [SLOT_W-1:0] slot_ff;
   logic [SLOT_W-1:0] slot_in;
   logic [SUM_W-1:0]  total_ff;
   logic [SUM_W-1:0]  total_in;
   logic [PROD_W-1:0] prod;

   assign total_in = total_ff - SUM_W'(hist_ff[slot_ff]) + SUM_W'(voltage);
   assign slot_in  = (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
   assign prod     = PROD_W'(total_in) * PROD_W'(RECIP);
   assign mean     = prod[SHIFT +: VOLT_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AVG_DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
         slot_ff  <= '0;
         total_ff <= '0;
      end else if (enable) begin
         hist_ff[slot_ff] <= voltage;
         slot_ff          <= slot_in;
         total_ff         <= total_in;
      end
   end

endmodule

// File: rtl/voltage_sag_throttle_limiter_top.sv
// ----------------------------------------------------------------------------
// voltage_sag_throttle_limiter_top
// Throttle limiter: voltage sag ramp-down, test sweep and voltage mean.
// Path: an accepted item is held in the input register, then its result in the result register.
// Throughput: one item per cycle while results are taken; one pass through the update logic per item.
// Reset: synchronous; clears state, voltage history and config to defaults.
// ----------------------------------------------------------------------------
module voltage_sag_throttle_limiter_top #(
   parameter int unsigned AVG_DEPTH = 5
) (
   input  logic                            clock,
   input  logic                            reset,
   vstl_req_if.sink                        req_ch,
   vstl_rsp_if.source                      rsp_ch,
   input  logic                            csr_we,
   input  logic [vstl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [vstl_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import vstl_pkg::*;

   logic [VOLT_W-1:0]      voltage_limit_ff;
   logic [RAMP_STEP_W-1:0] ramp_step_ff;
   logic [FLOOR_W-1:0]     ramp_floor_ff;
   logic [TEST_STEP_W-1:0] test_step_ff;

   logic         in_valid_ff;
   req_item_type in_item_ff;
   logic         out_valid_ff;
   rsp_item_type out_item_ff;
   rsp_item_type out_item_in;
   logic         advance;

   logic                      test_active_ff, test_active_in;
   logic [TIME_W-1:0]         next_step_time_ff, next_step_time_in;
   logic [STEP_W-1:0]         sweep_step_ff, sweep_step_in;
   logic [PCT_W-1:0]          held_pct_ff, held_pct_in;
   logic signed [LIMIT_W-1:0] limited_ff, limited_in;
   logic [VOLT_W-1:0]         mean;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   vstl_mean #(.AVG_DEPTH(AVG_DEPTH)) u_mean (
      .clock   (clock),
      .reset   (reset),
      .enable  (advance),
      .voltage (in_item_ff.voltage_mv),
      .mean    (mean)
   );

   always_comb begin
      logic                      ta_tog;
      logic [TIME_W-1:0]         nst_tog;
      logic [TIME_W-1:0]         deadline;
      logic [TIME_W-1:0]         nst_cmp;
      logic                      start;
      logic                      tick;
      logic                      done;
      logic [STEP_W-1:0]         step_a;
      logic [STEP_W-1:0]         step_b;
      logic [CMD_SUM_W-1:0]      sum;
      logic [PULSE_W-1:0]        cmd;
      logic signed [LIMIT_W-1:0] cmd_s;
      logic signed [LIMIT_W-1:0] floor_s;
      logic signed [LIMIT_W:0]   lim_ext;
      logic signed [LIMIT_W:0]   step_ext;
      logic signed [LIMIT_W:0]   lim_sum;
      logic [PULSE_W-1:0]        lim_clamp;
      logic                      manual;

      ta_tog   = test_active_ff ^ in_item_ff.test_toggle;
      nst_tog  = in_item_ff.test_toggle ? '0 : next_step_time_ff;
      deadline = in_item_ff.now_ms + TIME_W'(test_step_ff);
      start    = ta_tog && (nst_tog == '0);
      nst_cmp  = start ? deadline : nst_tog;
      tick     = ta_tog && (in_item_ff.now_ms > nst_cmp);
      step_a   = start ? '0 : sweep_step_ff;
      step_b   = tick ? step_a + 1'b1 : step_a;
      done     = ta_tog && (step_b > SWEEP_END);

      test_active_in    = ta_tog && !done;
      sweep_step_in     = test_active_in ? step_b : '0;
      next_step_time_in = (start || tick) ? deadline : nst_tog;

      sum = CMD_SUM_W'(in_item_ff.pulse_a) + CMD_SUM_W'(in_item_ff.pulse_b)
          + CMD_SUM_W'(in_item_ff.pulse_c) + CMD_SUM_W'(in_item_ff.pulse_d);
      cmd = ta_tog ? TEST_PULSE_TABLE[sweep_step_in] : sum[CMD_SUM_W-1:2];
      cmd_s = $signed({2'b00, cmd});

      floor_s  = $signed({2'b00, ramp_floor_ff});
      lim_ext  = {limited_ff[LIMIT_W-1], limited_ff};
      step_ext = $signed({5'b00000, ramp_step_ff});
      if (in_item_ff.voltage_mv < voltage_limit_ff && limited_ff >= floor_s) begin
         lim_sum = lim_ext - step_ext;
      end else if (limited_ff < cmd_s) begin
         lim_sum = lim_ext + step_ext;
      end else begin
         lim_sum = {cmd_s[LIMIT_W-1], cmd_s};
      end
      limited_in = lim_sum[LIMIT_W-1:0];

      held_pct_in = test_active_in ? held_pct_ff : pulse_to_percent(cmd_s);

      if (limited_in < 0) begin
         lim_clamp = '0;
      end else if (limited_in > 14'sd4095) begin
         lim_clamp = '1;
      end else begin
         lim_clamp = limited_in[PULSE_W-1:0];
      end

      manual = (in_item_ff.switch_pulse_a > SWITCH_LEVEL) &&
               (in_item_ff.switch_pulse_b > SWITCH_LEVEL);

      out_item_in.command_percent = held_pct_in;
      out_item_in.mean_voltage_mv = mean;
      if (test_active_in) begin
         out_item_in.drive_mode   = MODE_TEST;
         out_item_in.esc_pulse_us = cmd;
         out_item_in.ramp_percent = PCT_W'(sweep_step_in);
      end else if (!manual) begin
         out_item_in.drive_mode   = MODE_AUTO;
         out_item_in.esc_pulse_us = lim_clamp;
         out_item_in.ramp_percent = pulse_to_percent(limited_in);
      end else begin
         out_item_in.drive_mode   = MODE_MANUAL;
         out_item_in.esc_pulse_us = cmd;
         out_item_in.ramp_percent = held_pct_in;
      end

      priority if (done) begin
         out_item_in.serial_event = EVENT_END;
      end else if (tick) begin
         out_item_in.serial_event = EVENT_STEP;
      end else if (start) begin
         out_item_in.serial_event = EVENT_START;
      end else begin
         out_item_in.serial_event = EVENT_NONE;
      end
      out_item_in.serial_step = (tick && !done) ? step_b : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         voltage_limit_ff <= RST_VOLTAGE_LIMIT;
         ramp_step_ff     <= RST_RAMP_STEP;
         ramp_floor_ff    <= RST_RAMP_FLOOR;
         test_step_ff     <= RST_TEST_STEP;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_VOLTAGE_LIMIT: voltage_limit_ff <= csr_wdata[VOLT_W-1:0];
            CSR_RAMP_STEP:     ramp_step_ff     <= csr_wdata[RAMP_STEP_W-1:0];
            CSR_RAMP_FLOOR:    ramp_floor_ff    <= csr_wdata[FLOOR_W-1:0];
            CSR_TEST_STEP:     test_step_ff     <= csr_wdata[TEST_STEP_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         out_valid_ff      <= 1'b0;
         test_active_ff    <= 1'b0;
         next_step_time_ff <= '0;
         sweep_step_ff     <= '0;
         held_pct_ff       <= '0;
         limited_ff        <= '0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff      <= 1'b1;
            test_active_ff    <= test_active_in;
            next_step_time_ff <= next_step_time_in;
            sweep_step_ff     <= sweep_step_in;
            held_pct_ff       <= held_pct_in;
            limited_ff        <= limited_in;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_item_ff.voltage_mv     <= req_ch.voltage_mv;
         in_item_ff.pulse_a        <= req_ch.pulse_a;
         in_item_ff.pulse_b        <= req_ch.pulse_b;
         in_item_ff.pulse_c        <= req_ch.pulse_c;
         in_item_ff.pulse_d        <= req_ch.pulse_d;
         in_item_ff.switch_pulse_a <= req_ch.switch_pulse_a;
         in_item_ff.switch_pulse_b <= req_ch.switch_pulse_b;
         in_item_ff.test_toggle    <= req_ch.test_toggle;
         in_item_ff.now_ms         <= req_ch.now_ms;
      end
      if (advance) begin
         out_item_ff <= out_item_in;
      end
   end

   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.esc_pulse_us    = out_item_ff.esc_pulse_us;
   assign rsp_ch.drive_mode      = out_item_ff.drive_mode;
   assign rsp_ch.ramp_percent    = out_item_ff.ramp_percent;
   assign rsp_ch.command_percent = out_item_ff.command_percent;
   assign rsp_ch.mean_voltage_mv = out_item_ff.mean_voltage_mv;
   assign rsp_ch.serial_event    = out_item_ff.serial_event;
   assign rsp_ch.serial_step     = out_item_ff.serial_step;

   a_sweep_in_range: assert property (@(posedge clock) disable iff (reset)
      test_active_ff |-> sweep_step_ff <= SWEEP_END)
      else $error("sweep step beyond end while test active");

   a_step_event_value: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.serial_event == EVENT_STEP |->
         rsp_ch.serial_step != '0 && rsp_ch.serial_step <= SWEEP_END)
      else $error("step event without a valid step value");

   a_test_pulse_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.drive_mode == MODE_TEST |->
         rsp_ch.esc_pulse_us >= PULSE_MIN && rsp_ch.esc_pulse_us <= PULSE_MAX)
      else $error("test pulse outside sweep range");

   a_test_needs_toggle: assert property (@(posedge clock) disable iff (reset)
      !test_active_ff && !(advance && in_item_ff.test_toggle) |=> !test_active_ff)
      else $error("test mode entered without a toggle");

endmodule
